>>> hw/rtl/zsr_pkg.sv
// Shared types and codes for the zigzag scan reorder block
package zsr_pkg;

  // kind of an input word, carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // width of the side length field on the configuration port
  localparam int unsigned SIZE_W = 4;

  // payload widths of the stream words
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned COORD_W = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  // walker heading
  typedef enum logic [1:0] {
    DIR_RIGHT     = 2'd0,
    DIR_DOWN      = 2'd1,
    DIR_DOWN_LEFT = 2'd2,
    DIR_UP_RIGHT  = 2'd3
  } dir_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_DATA = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic store_wr;
    logic walk_step;
    logic ram_rd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

>>> hw/rtl/zigzag_scan_reorder_top.sv
// Top level of the zigzag scan reorder block
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: element_in; tuser: operation
//   m_axis    out        m_axis_tvalid/tready       tdata: element_out, row, column; tlast
//   cfg       in         cfg_wr_en_i                cfg_wr_data_i: matrix_size
//
// A write word is taken in the idle state; a read word passes through walker
// step, store address and registered store read before the next word is taken.
// The store read port is registered.
// Reset puts the side length at 8 (or MAX_SIZE if smaller), the load
// pointer at zero and the walker at the origin; the store needs no clearing.
// A stalled output holds its word, and a read stays in its last step
// until the output register is free.
module zigzag_scan_reorder_top #(
  parameter int unsigned MAX_SIZE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [zsr_pkg::SIZE_W-1:0]        cfg_wr_data_i,   // matrix_size
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [zsr_pkg::DATA_W-1:0]        s_axis_tdata,    // element_in
  input  logic                              s_axis_tuser,    // operation
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [zsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,    // element_out, row, column
  output logic                              m_axis_tlast
);
  import zsr_pkg::*;

  cmd_t                cmd;
  status_t             status;
  logic [DATA_W-1:0]   out_element;
  logic [COORD_W-1:0]  out_row;
  logic [COORD_W-1:0]  out_column;

  // controller
  zsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath
  zsr_datapath #(
    .MAX_SIZE     (MAX_SIZE),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_element_o(out_element),
    .out_row_o    (out_row),
    .out_column_o (out_column),
    .out_last_o   (m_axis_tlast)
  );

  // pack the output word, zero fill to whole bytes
  assign m_axis_tdata = {
    (OUT_TDATA_W - DATA_W - 2 * COORD_W)'(0), out_column, out_row, out_element
  };

endmodule

>>> hw/rtl/zsr_ram.sv
// Generic simple dual-port RAM with registered read
module zsr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  clk_i,
  wr_en_i,
  wr_addr_i,
  wr_data_i,
  rd_en_i,
  rd_addr_i,
  rd_data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk_i;
  input  logic             wr_en_i;
  input  logic [AW-1:0]    wr_addr_i;
  input  logic [WIDTH-1:0] wr_data_i;
  input  logic             rd_en_i;
  input  logic [AW-1:0]    rd_addr_i;
  output logic [WIDTH-1:0] rd_data_o;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/zsr_ctrl.sv
// Controller state machine: accepts words and sequences a zigzag read
module zsr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  input  zsr_pkg::status_t status_i,
  output zsr_pkg::cmd_t    cmd_o
);
  import zsr_pkg::*;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_READ) begin
            cmd_o.walk_step = 1'b1;
            state_d         = ST_ADDR;
          end else begin
            cmd_o.store_wr = 1'b1;
          end
        end
      end
      ST_ADDR: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = ST_DATA;
      end
      ST_DATA: begin
        if (!status_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/zsr_datapath.sv
// Datapath: element store, load pointer, zigzag walker and output register
module zsr_datapath #(
  parameter int unsigned MAX_SIZE      = 8,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [zsr_pkg::SIZE_W-1:0]    cfg_wr_data_i,
  input  logic [zsr_pkg::DATA_W-1:0]    in_data_i,
  input  zsr_pkg::cmd_t                 cmd_i,
  output zsr_pkg::status_t              status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [zsr_pkg::DATA_W-1:0]    out_element_o,
  output logic [zsr_pkg::COORD_W-1:0]   out_row_o,
  output logic [zsr_pkg::COORD_W-1:0]   out_column_o,
  output logic                          out_last_o
);
  import zsr_pkg::*;

  // side length is bounded by the parameter and by the 4-bit register
  localparam int unsigned SIZE_LIMIT = (1 << SIZE_W) - 1;
  localparam int unsigned EFF_MAX  = (MAX_SIZE < SIZE_LIMIT) ? MAX_SIZE : SIZE_LIMIT;
  localparam int unsigned CW       = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
  localparam int unsigned DEPTH    = EFF_MAX * EFF_MAX;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW       = $clog2(DEPTH + 1);
  localparam int unsigned SW       = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;
  localparam int unsigned RESET_N  = (EFF_MAX < 8) ? EFF_MAX : 8;

  logic [SIZE_W-1:0] n_q, n_d;
  logic [CW-1:0]     e_q, e_d;
  logic [TW-1:0]     total_q, total_d;
  logic [AW-1:0]     lp_q;
  logic [AW:0]       lp_inc;
  logic [CW-1:0]     row_q, row_d, col_q, col_d;
  dir_e              dir_q, dir_d;
  logic              started_q;
  logic              fin_d, fin_q;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     rd_data;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_element_q;
  logic [CW-1:0]     out_row_q, out_col_q;
  logic              out_last_q;
  logic [2*SIZE_W-1:0] n_sq;

  // clamp the written side length and derive edge index and element count
  always_comb begin
    n_d = cfg_wr_data_i;
    if (cfg_wr_data_i == '0) begin
      n_d = SIZE_W'(1);
    end else if (cfg_wr_data_i > SIZE_W'(EFF_MAX)) begin
      n_d = SIZE_W'(EFF_MAX);
    end
    n_sq    = (2*SIZE_W)'(n_d) * (2*SIZE_W)'(n_d);
    e_d     = CW'(n_d - SIZE_W'(1));
    total_d = TW'(n_sq);
  end

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= SIZE_W'(RESET_N);
      e_q     <= CW'(RESET_N - 1);
      total_q <= TW'(RESET_N * RESET_N);
    end else if (cfg_wr_en_i) begin
      n_q     <= n_d;
      e_q     <= e_d;
      total_q <= total_d;
    end
  end

  // row-major load pointer, wraps after n*n words
  assign lp_inc = {1'b0, lp_q} + (AW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (cfg_wr_en_i) begin
      lp_q <= '0;
    end else if (cmd_i.store_wr) begin
      if (TW'(lp_inc) == total_q) begin
        lp_q <= '0;
      end else begin
        lp_q <= AW'(lp_inc);
      end
    end
  end

  // zigzag walker step, clamped at the borders
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    dir_d = dir_q;
    if (!started_q) begin
      row_d = '0;
      col_d = '0;
      dir_d = DIR_RIGHT;
    end else begin
      case (dir_q)
        DIR_RIGHT: begin
          if (col_q < e_q) col_d = CW'(col_q + 1'b1);
          if (row_q == '0) begin
            dir_d = DIR_DOWN_LEFT;
          end else if (row_q == e_q) begin
            dir_d = DIR_UP_RIGHT;
          end
        end
        DIR_DOWN: begin
          if (row_q < e_q) row_d = CW'(row_q + 1'b1);
          if (col_q == '0) begin
            dir_d = DIR_UP_RIGHT;
          end else if (col_q == e_q) begin
            dir_d = DIR_DOWN_LEFT;
          end
        end
        DIR_DOWN_LEFT: begin
          if (row_q < e_q) row_d = CW'(row_q + 1'b1);
          if (col_q > '0)  col_d = CW'(col_q - 1'b1);
          if (col_d == '0) begin
            dir_d = (row_d == e_q) ? DIR_RIGHT : DIR_DOWN;
          end else if (row_d == e_q) begin
            dir_d = DIR_RIGHT;
          end
        end
        default: begin
          if (row_q > '0)  row_d = CW'(row_q - 1'b1);
          if (col_q < e_q) col_d = CW'(col_q + 1'b1);
          if (row_d == '0) begin
            dir_d = (col_d == e_q) ? DIR_DOWN : DIR_RIGHT;
          end else if (col_d == e_q) begin
            dir_d = DIR_DOWN;
          end
        end
      endcase
    end
    fin_d = (row_d == e_q) && (col_d == e_q);
  end

  // walker registers; after the corner the next read restarts at the origin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      dir_q     <= DIR_RIGHT;
      started_q <= 1'b0;
      fin_q     <= 1'b0;
    end else if (cfg_wr_en_i) begin
      row_q     <= '0;
      col_q     <= '0;
      dir_q     <= DIR_RIGHT;
      started_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      row_q     <= row_d;
      col_q     <= col_d;
      dir_q     <= dir_d;
      started_q <= !fin_d;
      fin_q     <= fin_d;
    end
  end

  // store address of the walker position
  assign rd_addr = AW'(row_q) * AW'(n_q) + AW'(col_q);

  zsr_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.store_wr),
    .wr_addr_i(lp_q),
    .wr_data_i(SW'(in_data_i)),
    .rd_en_i  (cmd_i.ram_rd),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_element_q <= DATA_W'(rd_data);
      out_row_q     <= row_q;
      out_col_q     <= col_q;
      out_last_q    <= fin_q;
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_element_o = out_element_q;
  assign out_row_o     = COORD_W'(out_row_q);
  assign out_column_o  = COORD_W'(out_col_q);
  assign out_last_o    = out_last_q;

  // load pointer stays inside the active matrix
  a_lp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    TW'(lp_q) < total_q)
    else $error("load pointer beyond active matrix");

  // walker never leaves the active matrix
  a_walker_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (row_q <= e_q) && (col_q <= e_q))
    else $error("walker outside active matrix");

  // a waiting output word is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("output word overwritten while stalled");

  // the final word sits on the diagonal corner
  a_last_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_row_q == out_col_q))
    else $error("last word off the diagonal");

endmodule

>>> verif/tb_zigzag_scan_reorder_top.sv
// Self-checking testbench for the zigzag scan reorder block
`timescale 1ns / 100ps

module tb_zigzag_scan_reorder_top;
  import zsr_pkg::*;

  localparam int MAX_SIDE      = 8;
  localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int RANDOM_ITEMS  = 700;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // one output word, split into its fields
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } scan_word_t;

  // walker position and heading
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    dir_e               dir;
    logic               started;
  } walker_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  // directed stimulus row; for ROW_CFG the data holds the side length
  typedef struct packed {
    row_kind_e         kind;
    logic              op;
    logic [DATA_W-1:0] data;
    logic              typed;
    scan_word_t        want;
  } stim_row_t;

  localparam scan_word_t NO_WORD = '0;
  localparam walker_t WALKER_HOME = '{row: '0, col: '0, dir: DIR_RIGHT, started: 1'b0};
  localparam int DIRECTED_LEN = 24;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // size one: every read is the origin, marked last
    '{ROW_CFG,  OP_WRITE, 16'd1,    1'b0, NO_WORD},
    '{ROW_ITEM, OP_WRITE, 16'hFFFF, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b1}},
    '{ROW_ITEM, OP_READ,  16'hFFFF, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b1}},
    '{ROW_ITEM, OP_WRITE, 16'h0000, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b1, '{16'h0000, 3'd0, 3'd0, 1'b1}},
    // size zero acts as one
    '{ROW_CFG,  OP_WRITE, 16'd0,    1'b0, NO_WORD},
    '{ROW_ITEM, OP_WRITE, 16'h8001, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b1, '{16'h8001, 3'd0, 3'd0, 1'b1}},
    // two by two: full scan, then the start of a second one
    '{ROW_CFG,  OP_WRITE, 16'd2,    1'b0, NO_WORD},
    '{ROW_ITEM, OP_WRITE, 16'h1234, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_WRITE, 16'h5678, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_WRITE, 16'h9ABC, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_WRITE, 16'hDEF0, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b1, '{16'h1234, 3'd0, 3'd0, 1'b0}},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b0, NO_WORD},
    // size rewritten mid-scan: walker and load pointer go home, store kept
    '{ROW_CFG,  OP_WRITE, 16'd2,    1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b1, '{16'h1234, 3'd0, 3'd0, 1'b0}},
    '{ROW_ITEM, OP_WRITE, 16'h0000, 1'b0, NO_WORD},
    '{ROW_ITEM, OP_READ,  16'h0000, 1'b0, NO_WORD}
  };

  localparam logic [SIZE_W-1:0] EXTREME_SIZES [4] = '{4'd15, 4'd8, 4'd0, 4'd1};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en_i   = 1'b0;
  logic [SIZE_W-1:0]      cfg_wr_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata  = '0;   // element_in
  logic                   s_axis_tuser  = OP_WRITE;  // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // element_out, row, column
  logic                   m_axis_tlast;

  // predictor state
  logic [DATA_W-1:0] store_model [STORE_DEPTH];
  bit                store_filled [STORE_DEPTH];
  logic [SIZE_W-1:0] size_reg = 4'd8;
  int                load_ptr = 0;
  walker_t           walk = WALKER_HOME;

  scan_word_t scan_words_due [$];
  int         fail_count  = 0;
  int         items_sent  = 0;
  int         burst_left  = 0;
  bit         steady      = 1'b0;
  int         stall_tick  = 0;
  int         stall_mode  = 0;

  zigzag_scan_reorder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("zigzag_scan_reorder_top test failed");
    $finish;
  end

  // side length in use for a register value
  function automatic int side_len(input logic [SIZE_W-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_SIDE) return MAX_SIDE;
    return int'(size);
  endfunction

  // one walker move with clamping and turns at the borders
  function automatic walker_t walker_step(input walker_t w, input int n);
    int e;
    e = n - 1;
    case (w.dir)
      DIR_RIGHT: begin
        if (w.col < e) w.col++;
        if (w.row == 0) w.dir = DIR_DOWN_LEFT;
        else if (w.row == e) w.dir = DIR_UP_RIGHT;
      end
      DIR_DOWN: begin
        if (w.row < e) w.row++;
        if (w.col == 0) w.dir = DIR_UP_RIGHT;
        else if (w.col == e) w.dir = DIR_DOWN_LEFT;
      end
      DIR_DOWN_LEFT: begin
        if (w.row < e) w.row++;
        if (w.col > 0) w.col--;
        if (w.col == 0) w.dir = (w.row == e) ? DIR_RIGHT : DIR_DOWN;
        else if (w.row == e) w.dir = DIR_RIGHT;
      end
      default: begin
        if (w.row > 0) w.row--;
        if (w.col < e) w.col++;
        if (w.row == 0) w.dir = (w.col == e) ? DIR_DOWN : DIR_RIGHT;
        else if (w.col == e) w.dir = DIR_DOWN;
      end
    endcase
    return w;
  endfunction

  // true when the next read lands on a store entry already written
  function automatic bit read_ready();
    walker_t w;
    int n;
    w = walk;
    n = side_len(size_reg);
    if (w.started) w = walker_step(w, n);
    return store_filled[w.row * n + w.col];
  endfunction

  // next zigzag word caused by one input word, updating the predictor state
  task automatic predict_scan_word(input logic op, input logic [DATA_W-1:0] data,
                                   output bit has, output scan_word_t word);
    int n;
    int addr;
    n = side_len(size_reg);
    has = 1'b0;
    word = NO_WORD;
    if (op == OP_WRITE) begin
      store_model[load_ptr] = data;
      store_filled[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= n * n) load_ptr = 0;
    end else begin
      if (walk.started) walk = walker_step(walk, n);
      walk.started = 1'b1;
      addr = walk.row * n + walk.col;
      word.value = store_model[addr];
      word.row = walk.row;
      word.col = walk.col;
      word.last = (walk.row == n - 1) && (walk.col == n - 1);
      if (word.last) walk = WALKER_HOME;
      has = 1'b1;
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // drive one input word in bursts with random gaps
  task automatic send_item(input logic op, input logic [DATA_W-1:0] data,
                           input bit typed, input scan_word_t typed_word);
    bit has;
    scan_word_t word;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    predict_scan_word(op, data, has, word);
    if (has) scan_words_due.push_back(typed ? typed_word : word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // stop sending and let every pending word drain
  task automatic settle_stream();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (scan_words_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // write the side length register while the block is idle
  task automatic set_size(input logic [SIZE_W-1:0] size);
    settle_stream();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= size;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    size_reg = size;
    load_ptr = 0;
    walk = WALKER_HOME;
  endtask

  // receiver stall pattern, switching to a randomly chosen mode now and again
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((stall_tick % 8) < 5);
    endcase
  end

  // compare each accepted output word with the oldest expectation
  always @(posedge clk_i) begin : check_words
    scan_word_t got;
    scan_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[DATA_W-1:0];
      got.row   = m_axis_tdata[DATA_W +: COORD_W];
      got.col   = m_axis_tdata[DATA_W + COORD_W +: COORD_W];
      got.last  = m_axis_tlast;
      if (scan_words_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected word: value %h row %0d col %0d last %b",
                   got.value, got.row, got.col, got.last);
      end else begin
        want = scan_words_due.pop_front();
        if (got.value !== want.value || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected value %h row %0d col %0d last %b, got value %h row %0d col %0d last %b",
                     want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
        end
      end
    end
  end

  // reset, directed rows, then random phases
  initial begin : stimulus
    int phase;
    int size_sel;
    int n;
    int reads;
    int count;
    logic op;
    phase = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG)
        set_size(DIRECTED_ROWS[i].data[SIZE_W-1:0]);
      else
        send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase < 4) size_sel = int'(EXTREME_SIZES[phase]);
      else if ($urandom_range(0, 4) == 0) size_sel = $urandom_range(8, 15);
      else size_sel = $urandom_range(0, 7);
      set_size(SIZE_W'(size_sel));
      n = side_len(SIZE_W'(size_sel));
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        // full load, then a full, double or partial scan
        repeat (n * n) send_item(OP_WRITE, rand_elem(), 1'b0, NO_WORD);
        if ($urandom_range(0, 3) == 0) reads = $urandom_range(1, n * n);
        else reads = n * n * $urandom_range(1, 2);
        repeat (reads) send_item(OP_READ, rand_elem(), 1'b0, NO_WORD);
        count = $urandom_range(0, n + 2);
      end else begin
        count = $urandom_range(4, 2 * n * n + 4);
      end
      // mixed words, reads only where the store entry holds data
      repeat (count) begin
        op = 1'($urandom_range(0, 1));
        if (op == OP_READ && !read_ready()) op = OP_WRITE;
        send_item(op, rand_elem(), 1'b0, NO_WORD);
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (scan_words_due.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("zigzag_scan_reorder_top test passed");
    else
      $display("zigzag_scan_reorder_top test failed");
    $finish;
  end

endmodule

>>> zigzag_scan_reorder_top.f
hw/rtl/zsr_pkg.sv
hw/rtl/zsr_ram.sv
hw/rtl/zsr_ctrl.sv
hw/rtl/zsr_datapath.sv
hw/rtl/zigzag_scan_reorder_top.sv
verif/tb_zigzag_scan_reorder_top.sv
